[src/ckrl_pkg.sv]
package ckrl_pkg;

    // Decoder phases within one compressed image.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_COUNT  = 3'd1,
        PH_SKIP   = 3'd2,
        PH_PUTLEN = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KEY    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET = 11'd1024;
    localparam logic [15:0] KEY_RESET    = 16'd0;

    // Live configuration as seen by the decoder.
    typedef struct packed {
        logic [10:0] width;
        logic [10:0] height;
        logic [15:0] key;
    } t_cfg;

    // One frame-store command.
    typedef struct packed {
        logic        overrun;
        logic        image_done;
        logic [15:0] pixel_value;
        logic [10:0] run_length;
        logic [9:0]  out_col;
        logic [9:0]  out_row;
    } t_result;

endpackage

[src/ckrl_step.sv]
module ckrl_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [15:0]      i_word,
    input  ckrl_pkg::t_cfg   i_cfg,
    output ckrl_pkg::t_result o_res0,
    output ckrl_pkg::t_result o_res1,
    output logic [1:0]       o_count
);

    localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
    localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

    ckrl_pkg::t_phase r_phase, n_phase;
    logic [11:0] r_header_left, n_header_left;
    logic [15:0] r_patterns_left, n_patterns_left;
    logic [15:0] r_data_left, n_data_left;
    logic [10:0] r_col, n_col;
    logic [10:0] r_row, n_row;

    logic [10:0] eff_w;
    logic [10:0] eff_h;

    // Clamp the live size registers to the supported range.
    always_comb begin
        eff_w = (i_cfg.width == 11'd0) ? 11'd1 : i_cfg.width;
        if ({2'b00, eff_w} > MaxW) begin
            eff_w = MaxW[10:0];
        end
        eff_h = (i_cfg.height == 11'd0) ? 11'd1 : i_cfg.height;
        if ({2'b00, eff_h} > MaxH) begin
            eff_h = MaxH[10:0];
        end
    end

    logic              prim_v;
    ckrl_pkg::t_result prim;
    logic              pat_end;
    logic              row_end;
    logic              fill_v;
    logic              last_row;
    ckrl_pkg::t_result fill;
    ckrl_pkg::t_result marker;
    logic [11:0]       hl;
    logic [10:0]       room;
    logic [16:0]       col_sum;
    logic [15:0]       pl_dec;
    logic [15:0]       dl_dec;
    logic [10:0]       col_e;

    // Per-word decode: one phase step plus the pattern and row end that it may cause.
    always_comb begin
        n_phase         = r_phase;
        n_header_left   = r_header_left;
        n_patterns_left = r_patterns_left;
        n_data_left     = r_data_left;
        n_col           = r_col;
        n_row           = r_row;
        prim_v          = 1'b0;
        prim            = '0;
        pat_end         = 1'b0;
        row_end         = 1'b0;
        hl              = (r_header_left == 12'd0) ? {eff_h, 1'b0} : r_header_left;
        room            = eff_w - r_col;
        col_sum         = {6'd0, r_col} + {1'b0, i_word};
        pl_dec          = r_patterns_left - 16'd1;
        dl_dec          = r_data_left - 16'd1;

        unique case (r_phase)
            ckrl_pkg::PH_HEADER: begin
                n_header_left = hl - 12'd1;
                if (hl == 12'd1) begin
                    n_phase = ckrl_pkg::PH_COUNT;
                    n_row   = 11'd0;
                    n_col   = 11'd0;
                end
            end
            ckrl_pkg::PH_COUNT: begin
                n_col           = 11'd0;
                n_patterns_left = i_word;
                if (i_word == 16'd0) begin
                    row_end = 1'b1;
                end else begin
                    n_phase = ckrl_pkg::PH_SKIP;
                end
            end
            ckrl_pkg::PH_SKIP: begin
                if (i_word != 16'd0 && r_col < eff_w) begin
                    prim_v           = 1'b1;
                    prim.out_row     = r_row[9:0];
                    prim.out_col     = r_col[9:0];
                    prim.pixel_value = i_cfg.key;
                    if (i_word > {5'd0, room}) begin
                        prim.run_length = room;
                        prim.overrun    = 1'b1;
                    end else begin
                        prim.run_length = i_word[10:0];
                    end
                end
                n_col   = (col_sum > {6'd0, eff_w}) ? eff_w : col_sum[10:0];
                n_phase = ckrl_pkg::PH_PUTLEN;
            end
            ckrl_pkg::PH_PUTLEN: begin
                n_data_left = i_word;
                if (i_word == 16'd0) begin
                    pat_end = 1'b1;
                end else begin
                    n_phase = ckrl_pkg::PH_DATA;
                end
            end
            ckrl_pkg::PH_DATA: begin
                if (r_col < eff_w) begin
                    prim_v           = 1'b1;
                    prim.out_row     = r_row[9:0];
                    prim.out_col     = r_col[9:0];
                    prim.run_length  = 11'd1;
                    prim.pixel_value = i_word;
                    prim.overrun     = (r_data_left > {5'd0, room});
                    n_col            = r_col + 11'd1;
                end
                n_data_left = dl_dec;
                if (dl_dec == 16'd0) begin
                    pat_end = 1'b1;
                end
            end
            default: begin
                n_phase       = ckrl_pkg::PH_HEADER;
                n_header_left = 12'd0;
            end
        endcase

        // Pattern end: count down, and close the row after the last pattern.
        if (pat_end) begin
            n_patterns_left = pl_dec;
            if (pl_dec == 16'd0) begin
                row_end = 1'b1;
            end else begin
                n_phase = ckrl_pkg::PH_SKIP;
            end
        end

        // Row end: fill the remainder, then step to the next row or finish the image.
        col_e    = n_col;
        fill_v   = row_end && (col_e < eff_w);
        last_row = row_end && (({1'b0, r_row} + 12'd1) >= {1'b0, eff_h});

        fill             = '0;
        fill.out_row     = r_row[9:0];
        fill.out_col     = col_e[9:0];
        fill.run_length  = eff_w - col_e;
        fill.pixel_value = i_cfg.key;

        marker             = '0;
        marker.out_row     = r_row[9:0];
        marker.pixel_value = i_cfg.key;

        if (row_end) begin
            n_col = 11'd0;
            if (last_row) begin
                n_phase       = ckrl_pkg::PH_HEADER;
                n_header_left = 12'd0;
                n_row         = 11'd0;
            end else begin
                n_phase = ckrl_pkg::PH_COUNT;
                n_row   = r_row + 11'd1;
            end
        end

        // Order the results; the image-done flag goes on the last one.
        o_res0  = '0;
        o_res1  = '0;
        o_count = 2'd0;
        if (prim_v) begin
            o_res0 = prim;
            if (fill_v) begin
                o_res1            = fill;
                o_res1.image_done = last_row;
                o_count           = 2'd2;
            end else begin
                o_res0.image_done = last_row;
                o_count           = 2'd1;
            end
        end else if (fill_v) begin
            o_res0            = fill;
            o_res0.image_done = last_row;
            o_count           = 2'd1;
        end else if (last_row) begin
            o_res0            = marker;
            o_res0.image_done = 1'b1;
            o_count           = 2'd1;
        end
    end

    // Decoder state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ckrl_pkg::PH_HEADER;
            r_header_left   <= 12'd0;
            r_patterns_left <= 16'd0;
            r_data_left     <= 16'd0;
            r_col           <= 11'd0;
            r_row           <= 11'd0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_header_left   <= n_header_left;
            r_patterns_left <= n_patterns_left;
            r_data_left     <= n_data_left;
            r_col           <= n_col;
            r_row           <= n_row;
        end
    end

endmodule

[src/ckrl_out_fifo.sv]
module ckrl_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_wr_count,
    input  ckrl_pkg::t_result i_wr0,
    input  ckrl_pkg::t_result i_wr1,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_rd,
    output ckrl_pkg::t_result o_head
);

    ckrl_pkg::t_result r_slot [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_count, n_count;
    logic       rd_en;

    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'd2);
    assign o_head  = r_slot[r_rp];
    assign rd_en   = i_rd && o_valid;

    // Pointer and fill-level bookkeeping.
    always_comb begin
        n_wp    = r_wp + i_wr_count;
        n_rp    = r_rp + {1'b0, rd_en};
        n_count = r_count + {1'b0, i_wr_count} - {2'b00, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Up to two words are written per cycle at consecutive slots.
    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_slot[r_wp] <= i_wr0;
        end
        if (i_wr_count == 2'd2) begin
            r_slot[r_wp + 2'd1] <= i_wr1;
        end
    end

endmodule

[src/color_key_run_length_sprite_decoder_core.sv]
// Color-key run-length sprite decoder. Each input word is one 16-bit word of the
// compressed stream: 2*height header words, then per row a pattern count and per
// pattern a skip length, an opaque length and the pixel words. Output words are
// frame-store commands (a color-key fill or a one-pixel write); tlast marks the last
// command of an image and tuser flags a run clipped at the row width. The block takes
// one input word per cycle; a word decodes in the cycle it is accepted and its one or
// two commands go into a four-entry result queue, and s_axis_tready drops while that
// queue holds more than two words, so throughput is bound only by the output side,
// which drains one command per cycle. Width and height are clamped to 1..MAX_WIDTH and
// 1..MAX_HEIGHT and are read live; write configuration only while the block is idle.
module color_key_run_length_sprite_decoder_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Compressed stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] stream_word
    // Frame-store commands out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [9:0] out_row, [19:10] out_col,
                                        // [30:20] run_length, [46:31] pixel_value,
                                        // [47] zero
    output logic        m_axis_tlast,   // image_done
    output logic        m_axis_tuser    // overrun
);

    ckrl_pkg::t_cfg    r_cfg;
    ckrl_pkg::t_result res0;
    ckrl_pkg::t_result res1;
    ckrl_pkg::t_result head;
    logic [1:0]        res_count;
    logic [1:0]        wr_count;
    logic              room2;
    logic              in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room2;
    assign in_accept     = s_axis_tvalid && room2;
    assign wr_count      = in_accept ? res_count : 2'd0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= ckrl_pkg::WIDTH_RESET;
            r_cfg.height <= ckrl_pkg::HEIGHT_RESET;
            r_cfg.key    <= ckrl_pkg::KEY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ckrl_pkg::REG_WIDTH:  r_cfg.width  <= i_cfg_data[10:0];
                ckrl_pkg::REG_HEIGHT: r_cfg.height <= i_cfg_data[10:0];
                ckrl_pkg::REG_KEY:    r_cfg.key    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ckrl_step #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (s_axis_tdata),
        .i_cfg    (r_cfg),
        .o_res0   (res0),
        .o_res1   (res1),
        .o_count  (res_count)
    );

    ckrl_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (wr_count),
        .i_wr0      (res0),
        .i_wr1      (res1),
        .o_room2    (room2),
        .o_valid    (m_axis_tvalid),
        .i_rd       (m_axis_tready),
        .o_head     (head)
    );

    // Pack the head command onto the output bus.
    assign m_axis_tdata = {1'b0, head.pixel_value, head.run_length, head.out_col, head.out_row};
    assign m_axis_tlast = head.image_done;
    assign m_axis_tuser = head.overrun;

endmodule

[tb/tb_color_key_run_length_sprite_decoder_core.sv]
module tb_color_key_run_length_sprite_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPRITE_MAX_WIDTH  = 1024;
    localparam int SPRITE_MAX_HEIGHT = 1024;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int RANDOM_WORDS      = 790;
    localparam int RANDOM_PHASES     = 10;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int FULL_ROWS         = 40;
    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Tracks the decoder state and the frame-store commands it must produce.
    class sprite_cmd_scoreboard;
        logic [10:0]      width_reg;
        logic [10:0]      height_reg;
        logic [15:0]      key_reg;
        ckrl_pkg::t_phase phase;
        int unsigned      header_left;
        int unsigned      patterns_left;
        int unsigned      data_left;
        int unsigned      cur_col;
        int unsigned      cur_row;
        int               step_cmds;
        ckrl_pkg::t_result pending_cmds[$];
        int               mismatches;
        int               cmds_checked;
        int               images_done;

        function new();
            width_reg     = ckrl_pkg::WIDTH_RESET;
            height_reg    = ckrl_pkg::HEIGHT_RESET;
            key_reg       = ckrl_pkg::KEY_RESET;
            phase         = ckrl_pkg::PH_HEADER;
            header_left   = 0;
            patterns_left = 0;
            data_left     = 0;
            cur_col       = 0;
            cur_row       = 0;
            step_cmds     = 0;
            mismatches    = 0;
            cmds_checked  = 0;
            images_done   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] data);
            case (index)
                ckrl_pkg::REG_WIDTH:  width_reg = data[10:0];
                ckrl_pkg::REG_HEIGHT: height_reg = data[10:0];
                ckrl_pkg::REG_KEY:    key_reg = data;
                default: ;
            endcase
        endfunction

        // Width and height are clamped and read live.
        function int unsigned active_width();
            if (width_reg == 0) return 1;
            if (width_reg > SPRITE_MAX_WIDTH) return SPRITE_MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned active_height();
            if (height_reg == 0) return 1;
            if (height_reg > SPRITE_MAX_HEIGHT) return SPRITE_MAX_HEIGHT;
            return height_reg;
        endfunction

        function void push_cmd(int unsigned col, int unsigned len, logic [15:0] value,
                               logic clipped);
            ckrl_pkg::t_result cmd;
            cmd.out_row     = 10'(cur_row);
            cmd.out_col     = 10'(col);
            cmd.run_length  = 11'(len);
            cmd.pixel_value = value;
            cmd.image_done  = 1'b0;
            cmd.overrun     = clipped;
            pending_cmds.push_back(cmd);
            step_cmds++;
        endfunction

        // Fill the rest of the row; on the last row, flag the image end.
        function void finish_row();
            int unsigned       w;
            ckrl_pkg::t_result last_cmd;
            w = active_width();
            if (cur_col < w) push_cmd(cur_col, w - cur_col, key_reg, 1'b0);
            if (cur_row + 1 >= active_height()) begin
                // A row end with nothing to write still needs a done marker.
                if (step_cmds == 0) push_cmd(0, 0, key_reg, 1'b0);
                last_cmd = pending_cmds.pop_back();
                last_cmd.image_done = 1'b1;
                pending_cmds.push_back(last_cmd);
                phase       = ckrl_pkg::PH_HEADER;
                header_left = 0;
                cur_row     = 0;
                cur_col     = 0;
            end else begin
                cur_row++;
                cur_col = 0;
                phase   = ckrl_pkg::PH_COUNT;
            end
        endfunction

        function void finish_pattern();
            patterns_left = (patterns_left - 1) & 32'hFFFF;
            if (patterns_left == 0) finish_row();
            else phase = ckrl_pkg::PH_SKIP;
        endfunction

        // Advance the decoder by one accepted stream word.
        function void note_word(logic [15:0] word);
            int unsigned w;
            int unsigned room;
            w = active_width();
            step_cmds = 0;
            case (phase)
                ckrl_pkg::PH_HEADER: begin
                    if (header_left == 0) header_left = 2 * active_height();
                    header_left--;
                    if (header_left == 0) begin
                        phase   = ckrl_pkg::PH_COUNT;
                        cur_row = 0;
                        cur_col = 0;
                    end
                end
                ckrl_pkg::PH_COUNT: begin
                    cur_col       = 0;
                    patterns_left = word;
                    if (word == 0) finish_row();
                    else phase = ckrl_pkg::PH_SKIP;
                end
                ckrl_pkg::PH_SKIP: begin
                    // A skip is a color-key fill, clipped at the row end.
                    if (word != 0 && cur_col < w) begin
                        room = w - cur_col;
                        if (word > room) push_cmd(cur_col, room, key_reg, 1'b1);
                        else push_cmd(cur_col, word, key_reg, 1'b0);
                    end
                    cur_col += word;
                    if (cur_col > w) cur_col = w;
                    phase = ckrl_pkg::PH_PUTLEN;
                end
                ckrl_pkg::PH_PUTLEN: begin
                    data_left = word;
                    if (word == 0) finish_pattern();
                    else phase = ckrl_pkg::PH_DATA;
                end
                ckrl_pkg::PH_DATA: begin
                    // Pixels that fall beyond the row produce nothing.
                    if (cur_col < w) begin
                        push_cmd(cur_col, 1, word, data_left > w - cur_col);
                        cur_col++;
                    end
                    data_left = (data_left - 1) & 32'hFFFF;
                    if (data_left == 0) finish_pattern();
                end
                default: begin
                    phase       = ckrl_pkg::PH_HEADER;
                    header_left = 0;
                end
            endcase
        endfunction

        task report_mismatch(string what, longint got_val, longint exp_val);
            $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                     cmds_checked, what, got_val, exp_val);
            mismatches++;
        endtask

        // Compare one output word against the oldest pending command.
        task check_cmd(logic [47:0] data, logic last, logic user);
            ckrl_pkg::t_result want;
            if (pending_cmds.size() == 0) begin
                report_mismatch("unexpected result word", data, 0);
                return;
            end
            want = pending_cmds.pop_front();
            if (data[9:0] !== want.out_row) report_mismatch("out_row", data[9:0], want.out_row);
            if (data[19:10] !== want.out_col)
                report_mismatch("out_col", data[19:10], want.out_col);
            if (data[30:20] !== want.run_length)
                report_mismatch("run_length", data[30:20], want.run_length);
            if (data[46:31] !== want.pixel_value)
                report_mismatch("pixel_value", data[46:31], want.pixel_value);
            if (data[47] !== 1'b0) report_mismatch("pad bit", data[47], 0);
            if (last !== want.image_done) report_mismatch("image_done", last, want.image_done);
            if (user !== want.overrun) report_mismatch("overrun", user, want.overrun);
            if (want.image_done) images_done++;
            cmds_checked++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    sprite_cmd_scoreboard sb = new();

    int     sink_hold = 0;
    bit     sink_calm = 1'b0;
    bit     source_calm = 1'b0;
    int     words_sent = 0;
    int     cfg_writes = 0;
    longint cycle_count = 0;

    color_key_run_length_sprite_decoder_core #(
        .MAX_WIDTH  (SPRITE_MAX_WIDTH),
        .MAX_HEIGHT (SPRITE_MAX_HEIGHT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none when calm.
    function automatic int idle_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: check each accepted word, then decide the next ready.
    initial begin : result_sink
        int gap;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_cmd(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                gap = idle_gap(sink_calm);
            end
        end
    end

    // Write width, height and key back to back; optionally poke the unused index.
    task automatic apply_settings(input logic [10:0] width, input logic [10:0] height,
                                  input logic [15:0] key, input bit with_spare);
        logic [1:0]  idx[4];
        logic [15:0] val[4];
        int          n;
        idx = '{ckrl_pkg::REG_WIDTH, ckrl_pkg::REG_HEIGHT, ckrl_pkg::REG_KEY, REG_SPARE};
        // Upper bits beyond the register width carry junk that must be dropped.
        val = '{{5'($urandom), width}, {5'($urandom), height}, key, 16'($urandom)};
        n = with_spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[k], val[k]);
            cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one stream word, after an optional gap, and note it once taken.
    task automatic send_word(input logic [15:0] word);
        int gap;
        gap = idle_gap(source_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(word);
        words_sent++;
    endtask

    // Stop offering words and wait until every pending command has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pick a word that fits the decoder's current phase, with some noise.
    function automatic logic [15:0] next_stream_word();
        int unsigned w;
        int unsigned room;
        int          r;
        w    = sb.active_width();
        room = (sb.cur_col < w) ? w - sb.cur_col : 0;
        r    = $urandom_range(0, 99);
        case (sb.phase)
            ckrl_pkg::PH_COUNT: begin
                if (r < 15) return 16'd0;
                if (r < 85) return 16'($urandom_range(1, 3));
                return 16'($urandom_range(4, 8));
            end
            ckrl_pkg::PH_SKIP: begin
                if (r < 30) return 16'd0;
                if (r < 75) return 16'($urandom_range(1, room + 2));
                if (r < 92) return 16'($urandom_range(1, 2 * w));
                return 16'($urandom);
            end
            ckrl_pkg::PH_PUTLEN: begin
                if (r < 15) return 16'd0;
                if (r < 75 || room > 12) return 16'($urandom_range(1, 6));
                // Run longer than the room left, to get clipped pixels.
                return 16'(room + $urandom_range(1, 3));
            end
            ckrl_pkg::PH_DATA: begin
                if (r < 8) return 16'h0000;
                if (r < 16) return 16'hFFFF;
                return 16'($urandom);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Main sequence: reset, directed image, clamped-size rows, random phases.
    initial begin : stimulus
        logic [15:0] directed_words[$];
        logic [10:0] width;
        logic [10:0] height;
        logic [15:0] key;
        int          r;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small 4x2 image: clipped skip, empty pattern, pixels past the row,
        // a clipped data run and a done marker, then an image of empty rows.
        apply_settings(11'd4, 11'd2, 16'hFFFF, 1'b1);
        directed_words = '{
            16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
            16'd3, 16'd1, 16'd2, 16'h0000, 16'hFFFF, 16'd0, 16'd0,
            16'd5, 16'd2, 16'h1234, 16'h8001,
            16'd1, 16'd2, 16'd3, 16'h00FF, 16'hFF00, 16'h7777,
            16'h1357, 16'h2468, 16'h9BDF, 16'hECA8, 16'd0, 16'd0
        };
        foreach (directed_words[k]) send_word(directed_words[k]);
        drain();

        // One-row header, then the height is raised to its clamped maximum so
        // a run of empty rows at full width goes through while the output
        // stalls; the image stays open and ends under the next settings.
        apply_settings(11'd2047, 11'd1, 16'h0000, 1'b0);
        send_word(16'hFFFF);
        send_word(16'h0000);
        drain();
        apply_settings(11'd2047, 11'd2047, 16'h0000, 1'b0);
        source_calm = 1'b1;
        sink_hold   = LONG_HOLD_CYCLES;
        repeat (FULL_ROWS) send_word(16'd0);
        drain();

        // Random phases; each may stop mid-image, so new settings apply live.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            if (r < 45) width = 11'($urandom_range(1, 12));
            else if (r < 65) width = 11'($urandom_range(13, 80));
            else if (r < 72) width = 11'd1;
            else if (r < 80) width = 11'(SPRITE_MAX_WIDTH);
            else if (r < 86) width = 11'd2047;
            else if (r < 92) width = 11'd0;
            else width = 11'($urandom_range(0, 2047));
            r = $urandom_range(0, 99);
            if (r < 70) height = 11'($urandom_range(1, 3));
            else if (r < 85) height = 11'($urandom_range(4, 6));
            else if (r < 93) height = 11'd0;
            else height = 11'($urandom_range(7, 8));
            r = $urandom_range(0, 99);
            if (r < 15) key = 16'h0000;
            else if (r < 30) key = 16'hFFFF;
            else key = 16'($urandom);
            apply_settings(width, height, key, 1'b0);
            sink_calm   = (p % 3 == 0);
            source_calm = (p % 4 == 1);
            repeat (RANDOM_WORDS / RANDOM_PHASES) send_word(next_stream_word());
            drain();
        end

        // Final settle and verdict.
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_cmds.size() != 0)
            sb.report_mismatch("commands never produced", sb.pending_cmds.size(), 0);
        $display("Sent %0d stream words with %0d register writes;", words_sent, cfg_writes);
        $display("checked %0d commands over %0d images, with clipping and stalls.",
                 sb.cmds_checked, sb.images_done);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
